[design/alme_pkg.sv]
// ----------------------------------------------------------------------------
// alme_pkg
// shared types and constants of the airtime link metric estimator
// ----------------------------------------------------------------------------
package alme_pkg;

  localparam int unsigned REG_COUNT = 6;

  typedef enum logic [2:0] {
    REG_RATE_OVERRIDE = 3'd0,
    REG_AIRTIME_OVERHEAD = 3'd1,
    REG_TEST_FRAME_BITS = 3'd2,
    REG_AIRTIME_MAX = 3'd3,
    REG_EWMA_WEIGHT = 3'd4,
    REG_MAX_AGE = 3'd5
  } reg_index_t;

  localparam logic [1:0] STATUS_GIVEN = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
  localparam logic [1:0] STATUS_GONE = 2'd2;
  localparam logic [1:0] STATUS_SKIP = 2'd3;

  localparam logic OP_PROBE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [19:0] ONE_MBPS = 20'd1000000;
  localparam logic [16:0] OVR_UNIT = 17'd100000;
  localparam logic [9:0] LOSS_FULL = 10'd1000;
  localparam logic [6:0] GAP_LIMIT = 7'd100;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

[design/alme_div.sv]
// ----------------------------------------------------------------------------
// alme_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module alme_div (
  input  logic               clk,
  input  logic               rst,
  input  alme_pkg::div_req_t req,
  output alme_pkg::div_rsp_t rsp
);
  import alme_pkg::*;

  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] dvs;
  logic [6:0]  count;
  logic        running;
  logic        done_r;
  logic [64:0] trial;

  assign trial = {rem, quo[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done_r <= 1'b0;
      count <= '0;
    end else begin
      done_r <= running && !req.start && (count == 7'd1);
      if (req.start) begin
        running <= 1'b1;
        quo <= req.dividend;
        rem <= '0;
        dvs <= req.divisor;
        count <= 7'd64;
      end else if (running) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          running <= 1'b0;
        end
      end
    end
  end

  // rem top bit is never set since divisor fits the remainder path
  assign rsp = '{done: done_r, quotient: quo};
endmodule

[design/alme_regs.sv]
// ----------------------------------------------------------------------------
// alme_regs
// apb configuration register file
// ----------------------------------------------------------------------------
module alme_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] rate_override,
  output logic [15:0] airtime_overhead,
  output logic [15:0] test_frame_bits,
  output logic [31:0] airtime_max,
  output logic [8:0]  ewma_weight,
  output logic [15:0] max_age
);
  import alme_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_override <= 16'd0;
      airtime_overhead <= 16'd75;
      test_frame_bits <= 16'd8192;
      airtime_max <= 32'hFFFF_FFFF;
      ewma_weight <= 9'd8;
      max_age <= 16'd64;
    end else if (wr) begin
      unique case (idx)
        REG_RATE_OVERRIDE: rate_override <= pwdata[15:0];
        REG_AIRTIME_OVERHEAD: airtime_overhead <= pwdata[15:0];
        REG_TEST_FRAME_BITS: test_frame_bits <= pwdata[15:0];
        REG_AIRTIME_MAX: airtime_max <= pwdata;
        REG_EWMA_WEIGHT: ewma_weight <= pwdata[8:0];
        REG_MAX_AGE: max_age <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_RATE_OVERRIDE: prdata = {16'd0, rate_override};
      REG_AIRTIME_OVERHEAD: prdata = {16'd0, airtime_overhead};
      REG_TEST_FRAME_BITS: prdata = {16'd0, test_frame_bits};
      REG_AIRTIME_MAX: prdata = airtime_max;
      REG_EWMA_WEIGHT: prdata = {23'd0, ewma_weight};
      REG_MAX_AGE: prdata = {16'd0, max_age};
      default: prdata = '0;
    endcase
  end
endmodule

[design/airtime_link_metric_estimator_unit.sv]
// ----------------------------------------------------------------------------
// airtime_link_metric_estimator_unit
// per-neighbor probe loss counting and airtime cost with one shared divider
// ----------------------------------------------------------------------------
// channel   | handshake                 | payload
// command   | start / busy              | opcode, neighbor_index, probe fields
// result    | done strobe, one cycle    | out_neighbor .. stored_interval
// config    | apb psel/penable/pready   | six registers at 4*i
// a probe runs read, probe, write and out from command to result transfer
// a tick runs up to four serial divider passes
// (base, ratio, ewma, cost); ratio and cost skip the divider when trivial
// after reset a clearing pass over all NEIGHBORS entries runs with busy high
// the result receiver cannot stall; busy stays high until done
// ----------------------------------------------------------------------------
module airtime_link_metric_estimator_unit #(
  parameter int NEIGHBORS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [5:0]  neighbor_index,
  input  logic [31:0] probe_seqno,
  input  logic [31:0] probe_interval,
  input  logic [1:0]  rate_status,
  input  logic [31:0] bitrate_bps,
  output logic        done,
  output logic [5:0]  out_neighbor,
  output logic        accepted,
  output logic [6:0]  lost_count,
  output logic [15:0] expected_count,
  output logic [15:0] received_count,
  output logic [9:0]  loss_rate_raw,
  output logic [9:0]  loss_rate_smooth,
  output logic [31:0] base_time,
  output logic [31:0] cost_metric,
  output logic [31:0] stored_interval,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import alme_pkg::*;

  localparam int AW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;

  typedef struct packed {
    logic [31:0] prev;
    logic [31:0] newest;
    logic [15:0] expct;
    logic [15:0] recv;
    logic [9:0]  smooth;
    logic [31:0] base;
    logic [31:0] cost;
    logic [31:0] ival;
  } entry_t;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_READ  = 10'b0000000100,
    S_PROBE = 10'b0000001000,
    S_BASE  = 10'b0000010000,
    S_RATIO = 10'b0000100000,
    S_EWMA  = 10'b0001000000,
    S_COST  = 10'b0010000000,
    S_WRITE = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  logic [15:0] rate_override, airtime_overhead, test_frame_bits, max_age;
  logic [31:0] airtime_max;
  logic [8:0]  ewma_weight;

  alme_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .rate_override, .airtime_overhead, .test_frame_bits, .airtime_max,
    .ewma_weight, .max_age
  );

  div_req_t dreq;
  div_rsp_t drsp;
  alme_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  entry_t      mem [NEIGHBORS];
  entry_t      rd_data;
  entry_t      ent;
  state_t      state;
  logic [AW:0] clr_count;
  logic        in_range;
  logic        op;
  logic [AW-1:0] nidx;
  logic [5:0]  nraw;
  logic [31:0] seq, ival_in, bps;
  logic [1:0]  status;
  logic        acc_r;
  logic [6:0]  gap_r;
  logic [9:0]  eraw;
  logic [63:0] base_rate_c;
  logic        base_max_c;
  logic        use_max;
  logic        launch;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  entry_t      wr_data;
  logic        div_wait;
  logic [8:0]  wgt;

  assign in_range = ({26'd0, neighbor_index} < 32'(NEIGHBORS));
  assign busy = (state != S_IDLE);
  assign wgt = (ewma_weight == 9'd0) ? 9'd1 : ewma_weight;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[nidx];
  end

  // probe update, combinational on the loaded entry
  logic [31:0] gap_full, dnew, negd;
  logic [6:0]  gap_c;
  logic        stale;
  logic [16:0] exp_sum, rcv_sum;
  always_comb begin
    gap_full = seq - ent.prev - 32'd1;
    gap_c = (gap_full[31] || gap_full > 32'(GAP_LIMIT)) ? 7'd0 : gap_full[6:0];
    if (ent.prev == 32'd0) gap_c = 7'd0;
    exp_sum = {1'b0, ent.expct} + 17'd1 + 17'(gap_c);
    rcv_sum = {1'b0, ent.recv} + 17'd1;
    dnew = seq - ent.newest;
    negd = 32'd0 - dnew;
    stale = (dnew == 32'd0 || dnew[31]) && (negd < {16'd0, max_age});
  end

  // link bitrate for the base airtime division, override first
  always_comb begin
    base_max_c = 1'b0;
    priority if (rate_override != 16'd0) begin
      base_rate_c = 64'(33'(rate_override) * 33'(OVR_UNIT));
    end else if (status == STATUS_GONE) begin
      base_rate_c = '0;
      base_max_c = 1'b1;
    end else if (status == STATUS_UNKNOWN) begin
      base_rate_c = 64'(ONE_MBPS);
    end else begin
      base_rate_c = {32'd0, bps};
    end
    if (base_rate_c == 64'd0) base_max_c = 1'b1;
  end

  // a division step issues at most one divider start, registered from its first cycle
  assign launch = !div_wait && ((state == S_BASE) || (state == S_EWMA)
                  || (state == S_RATIO && ent.expct != 16'd0)
                  || (state == S_COST && ent.smooth != LOSS_FULL));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_count <= '0;
      done <= 1'b0;
      dreq.start <= 1'b0;
      wr_en <= 1'b0;
      div_wait <= 1'b0;
    end else begin
      done <= (state == S_OUT);
      dreq.start <= launch;
      wr_en <= (state == S_CLEAR) || (state == S_WRITE);
      unique case (state)
        S_CLEAR: begin
          wr_addr <= clr_count[AW-1:0];
          wr_data <= '0;
          clr_count <= clr_count + (AW+1)'(1);
          if (clr_count == (AW+1)'(NEIGHBORS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op <= opcode;
            nraw <= neighbor_index;
            nidx <= AW'(neighbor_index);
            seq <= probe_seqno;
            ival_in <= probe_interval;
            status <= rate_status;
            bps <= bitrate_bps;
            acc_r <= 1'b0;
            gap_r <= '0;
            eraw <= '0;
            if (!in_range) begin
              ent <= '0;
              state <= S_OUT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // read data lands in the cycle after the address registers
          if (div_wait) begin
            div_wait <= 1'b0;
            ent <= rd_data;
            if (op == OP_PROBE) begin
              state <= S_PROBE;
            end else if (status == STATUS_SKIP) begin
              state <= S_OUT;
            end else begin
              state <= S_BASE;
            end
          end else begin
            div_wait <= 1'b1;
          end
        end
        S_PROBE: begin
          gap_r <= gap_c;
          if (ent.prev == 32'd0) begin
            ent.expct <= 16'd1;
            ent.recv <= 16'd1;
          end else begin
            ent.expct <= exp_sum[16] ? 16'hFFFF : exp_sum[15:0];
            ent.recv <= rcv_sum[16] ? 16'hFFFF : rcv_sum[15:0];
          end
          ent.prev <= seq;
          acc_r <= !stale;
          if (!stale) begin
            ent.newest <= seq;
            ent.ival <= ival_in;
          end
          state <= S_WRITE;
        end
        S_BASE: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
            use_max <= base_max_c;
            dreq.dividend <= 64'(36'(test_frame_bits) * 36'(ONE_MBPS));
            dreq.divisor <= base_rate_c;
          end else if (drsp.done) begin
            div_wait <= 1'b0;
            if (use_max) begin
              ent.base <= airtime_max;
            end else if ((drsp.quotient + 64'(airtime_overhead)) > 64'hFFFF_FFFF) begin
              ent.base <= 32'hFFFF_FFFF;
            end else begin
              ent.base <= drsp.quotient[31:0] + 32'(airtime_overhead);
            end
            state <= S_RATIO;
          end
        end
        S_RATIO: begin
          if (ent.expct == 16'd0) begin
            eraw <= '0;
            state <= S_EWMA;
          end else if (!div_wait) begin
            div_wait <= 1'b1;
            dreq.dividend <= 64'(26'(ent.recv) * 26'(LOSS_FULL));
            dreq.divisor <= 64'(ent.expct);
          end else if (drsp.done) begin
            div_wait <= 1'b0;
            eraw <= (drsp.quotient >= 64'(LOSS_FULL)) ? 10'd0
                    : LOSS_FULL - drsp.quotient[9:0];
            state <= S_EWMA;
          end
        end
        S_EWMA: begin
          if (!div_wait) begin
            div_wait <= 1'b1;
            dreq.dividend <= 64'(eraw) + 64'(18'(wgt - 9'd1) * 18'(ent.smooth));
            dreq.divisor <= 64'(wgt);
          end else if (drsp.done) begin
            div_wait <= 1'b0;
            ent.smooth <= (drsp.quotient > 64'(LOSS_FULL)) ? LOSS_FULL
                          : drsp.quotient[9:0];
            ent.expct <= '0;
            ent.recv <= '0;
            state <= S_COST;
          end
        end
        S_COST: begin
          if (ent.smooth == LOSS_FULL) begin
            ent.cost <= airtime_max;
            state <= S_WRITE;
          end else if (!div_wait) begin
            div_wait <= 1'b1;
            dreq.dividend <= 64'(42'(ent.base) * 42'(LOSS_FULL));
            dreq.divisor <= 64'(LOSS_FULL - ent.smooth);
          end else if (drsp.done) begin
            div_wait <= 1'b0;
            ent.cost <= (drsp.quotient > 64'(airtime_max)) ? airtime_max
                        : drsp.quotient[31:0];
            acc_r <= 1'b1;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (op == OP_TICK) acc_r <= 1'b1;
          wr_addr <= nidx;
          wr_data <= ent;
          state <= S_OUT;
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result registers, valid while done is high
  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      out_neighbor <= nraw;
      accepted <= acc_r;
      lost_count <= gap_r;
      expected_count <= ent.expct;
      received_count <= ent.recv;
      loss_rate_raw <= eraw;
      loss_rate_smooth <= ent.smooth;
      base_time <= ent.base;
      cost_metric <= ent.cost;
      stored_interval <= ent.ival;
    end
  end

`ifndef ASSERT_OFF
  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command transfer did not raise busy");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == S_BASE || state == S_RATIO || state == S_EWMA
                   || state == S_COST))
    else $error("divider finished outside a division step");
`endif
endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// checks the airtime link metric estimator: a predictor keeps its own copy
// of the neighbor tables and registers, and every result strobe is compared
// field by field against the oldest predicted result, under random idling
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import alme_pkg::*;

  typedef struct packed {
    logic        op;
    logic [5:0]  nbr;
    logic [31:0] seq;
    logic [31:0] ival;
    logic [1:0]  status;
    logic [31:0] bps;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  nbr;
    logic        acc;
    logic [6:0]  lost;
    logic [15:0] exp_cnt;
    logic [15:0] rcv_cnt;
    logic [9:0]  raw;
    logic [9:0]  smooth;
    logic [31:0] base;
    logic [31:0] cost;
    logic [31:0] ival;
  } metric_t;

  logic clk = 0, rst = 1;
  logic start = 0, busy, done;
  logic opcode = 0;
  logic [5:0] neighbor_index = 0;
  logic [31:0] probe_seqno = 0, probe_interval = 0, bitrate_bps = 0;
  logic [1:0] rate_status = 0;
  logic [5:0] out_neighbor;
  logic accepted;
  logic [6:0] lost_count;
  logic [15:0] expected_count, received_count;
  logic [9:0] loss_rate_raw, loss_rate_smooth;
  logic [31:0] base_time, cost_metric, stored_interval;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;

  airtime_link_metric_estimator_unit DUT (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [15:0] p_override, p_overhead, p_frame_bits, p_max_age;
  logic [31:0] p_airtime_max;
  logic [8:0]  p_weight;
  logic [31:0] t_prev[64], t_newest[64], t_base[64], t_cost[64], t_ival[64];
  logic [15:0] t_exp[64], t_rcv[64];
  logic [9:0]  t_smooth[64];

  cmd_t    pending_cmds[$];
  metric_t expected_metrics[$];
  int errors = 0;
  int send_idle = 0;
  bit hold_send = 0;
  longint cycles = 0;

  function automatic metric_t predict_metric(cmd_t c);
    metric_t r;
    int unsigned n;
    logic [31:0] gap, d, neg;
    logic [63:0] rate, base, cost;
    logic [31:0] ratio, loss, w, s;
    logic stale, gone;
    r = '0;
    n = c.nbr;
    r.nbr = c.nbr;
    if (c.op == OP_PROBE) begin
      gap = 0;
      if (t_prev[n] != 0) begin
        gap = c.seq - t_prev[n] - 1;
        if (gap[31] || gap > 100) gap = 0;
        t_exp[n] = (t_exp[n] + 1 + gap > 32'hFFFF) ? 16'hFFFF : t_exp[n] + 1 + gap;
        t_rcv[n] = (t_rcv[n] == 16'hFFFF) ? 16'hFFFF : t_rcv[n] + 1;
      end else begin
        t_exp[n] = 1;
        t_rcv[n] = 1;
      end
      t_prev[n] = c.seq;
      d = c.seq - t_newest[n];
      neg = 0 - d;
      stale = (d == 0 || d[31]) && neg < p_max_age;
      if (!stale) begin
        t_newest[n] = c.seq;
        t_ival[n] = c.ival;
      end
      r.acc = !stale;
      r.lost = gap[6:0];
    end else if (c.status != STATUS_SKIP) begin
      gone = 0;
      rate = 0;
      if (p_override != 0) rate = 64'(p_override) * 100000;
      else if (c.status == STATUS_GONE) gone = 1;
      else if (c.status == STATUS_UNKNOWN) rate = 1000000;
      else rate = c.bps;
      if (gone || rate == 0) base = p_airtime_max;
      else begin
        base = 64'(p_overhead) + (64'(p_frame_bits) * 1000000) / rate;
        if (base > 64'hFFFFFFFF) base = 64'hFFFFFFFF;
      end
      t_base[n] = base[31:0];
      loss = 0;
      if (t_exp[n] != 0) begin
        ratio = 32'(t_rcv[n]) * 1000 / 32'(t_exp[n]);
        loss = ratio >= 1000 ? 0 : 1000 - ratio;
      end
      w = p_weight == 0 ? 1 : p_weight;
      s = (loss + (w - 1) * t_smooth[n]) / w;
      if (s > 1000) s = 1000;
      t_smooth[n] = s[9:0];
      t_exp[n] = 0;
      t_rcv[n] = 0;
      if (s < 1000) begin
        cost = base * 1000 / (1000 - s);
        if (cost > p_airtime_max) cost = p_airtime_max;
      end else cost = p_airtime_max;
      t_cost[n] = cost[31:0];
      r.acc = 1;
      r.raw = loss[9:0];
    end
    r.exp_cnt = t_exp[n];
    r.rcv_cnt = t_rcv[n];
    r.smooth = t_smooth[n];
    r.base = t_base[n];
    r.cost = t_cost[n];
    r.ival = t_ival[n];
    return r;
  endfunction

  // command driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) begin
        expected_metrics.push_back(predict_metric(pending_cmds.pop_front()));
      end
      if ((start && !busy) || !start) begin
        if (pending_cmds.size() != 0 &&
            (!hold_send || (expected_metrics.size() == 0 && !busy)) &&
            $urandom_range(99) >= send_idle) begin
          start <= 1;
          opcode <= pending_cmds[0].op;
          neighbor_index <= pending_cmds[0].nbr;
          probe_seqno <= pending_cmds[0].seq;
          probe_interval <= pending_cmds[0].ival;
          rate_status <= pending_cmds[0].status;
          bitrate_bps <= pending_cmds[0].bps;
        end else begin
          start <= 0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    metric_t got, want;
    if (!rst && done) begin
      got = {out_neighbor, accepted, lost_count, expected_count, received_count,
             loss_rate_raw, loss_rate_smooth, base_time, cost_metric,
             stored_interval};
      if (expected_metrics.size() == 0) begin
        $display("%0t unexpected result transfer %p", $realtime, got);
        errors++;
      end else begin
        want = expected_metrics.pop_front();
        if (got != want) begin
          $display("%0t mismatch expected %p actual %p", $realtime, want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_RATE_OVERRIDE:    p_override = val[15:0];
      REG_AIRTIME_OVERHEAD: p_overhead = val[15:0];
      REG_TEST_FRAME_BITS:  p_frame_bits = val[15:0];
      REG_AIRTIME_MAX:      p_airtime_max = val;
      REG_EWMA_WEIGHT:      p_weight = val[8:0];
      default:              p_max_age = val[15:0];
    endcase
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || start || busy || expected_metrics.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.op = $urandom_range(99) < 75 ? OP_PROBE : OP_TICK;
    c.nbr = $urandom_range(99) < 80 ? 6'($urandom_range(7)) : 6'($urandom);
    c.seq = $urandom_range(9) == 0 ? $urandom : $urandom_range(400);
    c.ival = $urandom;
    c.status = 2'($urandom);
    c.bps = $urandom_range(3) == 0 ? $urandom : $urandom_range(60000000);
    return c;
  endfunction

  // well-formed probe train: mostly in-order seqnos with a few gaps, then a tick
  task automatic push_train(int len);
    logic [5:0] n;
    logic [31:0] s;
    n = 6'($urandom_range(15));
    s = $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 5000);
    repeat (len) begin
      pending_cmds.push_back({OP_PROBE, n, s, 32'($urandom), STATUS_GIVEN, 32'd0});
      s = s + 1 + ($urandom_range(4) == 0 ? $urandom_range(120) : 0);
    end
    pending_cmds.push_back({OP_TICK, n, 32'd0, 32'd0, 2'($urandom_range(2)),
                            32'($urandom_range(1, 300000000))});
  endtask

  initial begin
    p_override = 0; p_overhead = 75; p_frame_bits = 8192;
    p_airtime_max = 32'hFFFFFFFF; p_weight = 8; p_max_age = 64;
    for (int i = 0; i < 64; i++) begin
      t_prev[i] = 0; t_newest[i] = 0; t_base[i] = 0; t_cost[i] = 0;
      t_ival[i] = 0; t_exp[i] = 0; t_rcv[i] = 0; t_smooth[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: extremes, wrap, stale, skip, gone
    pending_cmds.push_back({OP_PROBE, 6'd0, 32'd5, 32'hFFFFFFFF, STATUS_GIVEN, 32'd0});
    pending_cmds.push_back({OP_PROBE, 6'd0, 32'd7, 32'd10, STATUS_GIVEN, 32'd0});
    pending_cmds.push_back({OP_PROBE, 6'd0, 32'd200, 32'd11, STATUS_GIVEN, 32'd0});
    pending_cmds.push_back({OP_PROBE, 6'd0, 32'd150, 32'd12, STATUS_GIVEN, 32'd0});
    pending_cmds.push_back({OP_PROBE, 6'd0, 32'd300, 32'd13, STATUS_GIVEN, 32'd0});
    pending_cmds.push_back({OP_PROBE, 6'd0, 32'd300, 32'd14, STATUS_GIVEN, 32'd0});
    pending_cmds.push_back({OP_PROBE, 6'd0, 32'd401, 32'd15, STATUS_GIVEN, 32'd0});
    pending_cmds.push_back({OP_TICK, 6'd0, 32'd0, 32'd0, STATUS_GIVEN, 32'hFFFFFFFF});
    pending_cmds.push_back({OP_TICK, 6'd0, 32'd0, 32'd0, STATUS_GIVEN, 32'd0});
    pending_cmds.push_back({OP_TICK, 6'd0, 32'd0, 32'd0, STATUS_UNKNOWN, 32'd0});
    pending_cmds.push_back({OP_TICK, 6'd0, 32'd0, 32'd0, STATUS_GONE, 32'd1});
    pending_cmds.push_back({OP_TICK, 6'd0, 32'd0, 32'd0, STATUS_SKIP, 32'd1});
    pending_cmds.push_back({OP_TICK, 6'd0, 32'd0, 32'd0, STATUS_GIVEN, 32'd1});
    pending_cmds.push_back({OP_PROBE, 6'd63, 32'hFFFFFFFF, 32'd1, STATUS_GIVEN, 32'd0});
    pending_cmds.push_back({OP_PROBE, 6'd63, 32'd0, 32'd2, STATUS_GIVEN, 32'd0});
    pending_cmds.push_back({OP_PROBE, 6'd63, 32'd1, 32'd3, STATUS_GIVEN, 32'd0});
    pending_cmds.push_back({OP_PROBE, 6'd63, 32'h80000001, 32'd4, STATUS_GIVEN, 32'd0});
    pending_cmds.push_back({OP_TICK, 6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, STATUS_GIVEN,
                            32'd1000});
    drain();

    // hold-off: each command waits until every earlier result is in
    hold_send = 1;
    pending_cmds.push_back({OP_PROBE, 6'd1, 32'd1, 32'd1, STATUS_GIVEN, 32'd0});
    repeat (5) pending_cmds.push_back(rand_cmd());
    drain();
    hold_send = 0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_RATE_OVERRIDE, 32'd42949);
          write_reg(REG_AIRTIME_OVERHEAD, 32'd65535);
          write_reg(REG_TEST_FRAME_BITS, 32'd65535);
          write_reg(REG_AIRTIME_MAX, 32'd0);
          write_reg(REG_EWMA_WEIGHT, 32'd256);
          write_reg(REG_MAX_AGE, 32'd65535);
        end
        1: begin
          write_reg(REG_RATE_OVERRIDE, 32'd0);
          write_reg(REG_AIRTIME_OVERHEAD, 32'd0);
          write_reg(REG_TEST_FRAME_BITS, 32'd1);
          write_reg(REG_AIRTIME_MAX, 32'hFFFFFFFF);
          write_reg(REG_EWMA_WEIGHT, 32'd1);
          write_reg(REG_MAX_AGE, 32'd1);
        end
        2: begin
          write_reg(REG_EWMA_WEIGHT, 32'd0);
          write_reg(REG_AIRTIME_MAX, 32'd5000);
          write_reg(REG_RATE_OVERRIDE, 32'd1);
        end
        default: begin
          write_reg(REG_RATE_OVERRIDE, $urandom_range(3) == 0 ? $urandom_range(42949) : 0);
          write_reg(REG_AIRTIME_OVERHEAD, $urandom_range(65535));
          write_reg(REG_TEST_FRAME_BITS, $urandom_range(1, 65535));
          write_reg(REG_AIRTIME_MAX, $urandom);
          write_reg(REG_EWMA_WEIGHT, $urandom_range(1, 256));
          write_reg(REG_MAX_AGE, $urandom_range(1, 65535));
        end
      endcase
      case (ph % 4)
        0: send_idle = 0;
        1: send_idle = 67;
        2: send_idle = 38;
        default: send_idle = 0;
      endcase
      for (int k = 0; k < 205; ) begin
        int qlen;
        qlen = pending_cmds.size();
        if ($urandom_range(9) < 6) begin
          push_train($urandom_range(2, 12));
          k += pending_cmds.size() - qlen;
        end else begin
          pending_cmds.push_back(rand_cmd());
          k++;
        end
        while (pending_cmds.size() > 4) @(posedge clk);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[files.f]
design/alme_pkg.sv
design/alme_div.sv
design/alme_regs.sv
design/airtime_link_metric_estimator_unit.sv
sim/tb_top.sv
